FILE: hdl/kirw_pkg.sv
// ----------------------------------------------------------------------------
// kirw_pkg
// Shared types, constants and mixing functions for the keyed index random
// word generator.
// ----------------------------------------------------------------------------
package kirw_pkg;

  localparam int KeyWords  = 6;
  localparam int WordBits  = 32;
  localparam int IndexBits = 64;
  localparam int CfgIdxBits = 3;

  typedef logic [WordBits-1:0] word_t;
  typedef word_t [KeyWords-1:0] words_t;

  // The mixing round is split into three sub-rounds, one per pipeline stage.
  typedef enum logic [1:0] {
    ROUND_A,
    ROUND_B,
    ROUND_C
  } round_t;

  function automatic word_t rol32(word_t x, logic [4:0] r);
    return (x << r) | (x >> (6'd32 - {1'b0, r}));
  endfunction

  function automatic words_t mix_sub(words_t win, round_t rnd);
    words_t     w;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [4:0] rc;
    logic       sub1;
    logic       sub3;
    logic       sub5;
    unique case (rnd)
      ROUND_A: begin
        ra = 5'd7;  rb = 5'd9;  rc = 5'd13; sub1 = 1'b1; sub3 = 1'b0; sub5 = 1'b0;
      end
      ROUND_B: begin
        ra = 5'd18; rb = 5'd7;  rc = 5'd9;  sub1 = 1'b0; sub3 = 1'b1; sub5 = 1'b0;
      end
      ROUND_C: begin
        ra = 5'd13; rb = 5'd18; rc = 5'd12; sub1 = 1'b0; sub3 = 1'b0; sub5 = 1'b1;
      end
      default: begin
        ra = 5'd7;  rb = 5'd9;  rc = 5'd13; sub1 = 1'b1; sub3 = 1'b0; sub5 = 1'b0;
      end
    endcase
    w    = win;
    w[0] = rol32(w[0], ra);
    w[1] = sub1 ? (w[1] - w[0]) : (w[1] + w[0]);
    w[2] = rol32(w[2] ^ w[1], rb);
    w[3] = sub3 ? (w[3] - w[2]) : (w[3] + w[2]);
    w[4] = rol32(w[4] ^ w[3], rc);
    w[5] = sub5 ? (w[5] - w[4]) : (w[5] + w[4]);
    w[0] = w[0] ^ w[5];
    return w;
  endfunction

endpackage

FILE: hdl/kirw_inject.sv
// ----------------------------------------------------------------------------
// kirw_inject
// First pipeline stage: folds the stream index into the key words.
// ----------------------------------------------------------------------------
module kirw_inject (
  input  logic                                clk,
  input  logic                                rst,
  input  kirw_pkg::words_t                    key,
  input  logic                                valid_up,
  input  logic [kirw_pkg::IndexBits-1:0]      index_up,
  output logic                                stall_up,
  output logic                                valid,
  output kirw_pkg::words_t                    words,
  input  logic                                stall_down
);

  logic             ready;
  kirw_pkg::word_t  lo;
  kirw_pkg::word_t  hi;
  kirw_pkg::words_t words_next;

  // The stage can load when it is empty or its content moves on.
  assign ready    = !valid || !stall_down;
  assign stall_up = !ready;

  assign lo = index_up[kirw_pkg::WordBits-1:0];
  assign hi = index_up[kirw_pkg::IndexBits-1:kirw_pkg::WordBits];

  always_comb begin
    words_next    = key;
    words_next[0] = key[0] + lo;
    words_next[1] = key[1] ^ lo;
    words_next[2] = key[2] + hi;
    words_next[3] = key[3] ^ hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_up) begin
      words <= words_next;
    end
  end

endmodule

FILE: hdl/kirw_mix_stage.sv
// ----------------------------------------------------------------------------
// kirw_mix_stage
// One registered sub-round of the mixing function with its valid bit.
// ----------------------------------------------------------------------------
module kirw_mix_stage (
  input  logic              clk,
  input  logic              rst,
  input  kirw_pkg::round_t  rnd,
  input  logic              valid_up,
  input  kirw_pkg::words_t  words_up,
  output logic              stall_up,
  output logic              valid,
  output kirw_pkg::words_t  words,
  input  logic              stall_down
);

  logic ready;

  assign ready    = !valid || !stall_down;
  assign stall_up = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_up) begin
      words <= kirw_pkg::mix_sub(words_up, rnd);
    end
  end

endmodule

FILE: hdl/keyed_index_random_word.sv
// ----------------------------------------------------------------------------
// keyed_index_random_word
// Counter-based random word generator keyed by six configuration words.
// ----------------------------------------------------------------------------
// Throughput: one index per cycle while the result side does not stall; four
// register stages (key injection and three mixing sub-rounds) each hold one
// transaction, and the last of them drives the result at the port.
// Reset clears all key words to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module keyed_index_random_word (
  input  logic                                 clk,
  input  logic                                 rst,
  // Index channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kirw_pkg::IndexBits-1:0]       stream_index,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kirw_pkg::WordBits-1:0]        random_word,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kirw_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [kirw_pkg::WordBits-1:0]        cfg_data
);

  // The key registers. A write is always taken in its own cycle; indexes
  // past the last key word are accepted and dropped.
  kirw_pkg::words_t key;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready &&
                 (32'(cfg_index) < kirw_pkg::KeyWords)) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // Pipeline. Each stage holds a transaction with its valid bit and loads
  // whenever it is empty or its content moves to the next stage, so bubbles
  // are squeezed out and a stalled result never blocks the earlier stages
  // while they still have room.
  logic             s0_valid, s1_valid, s2_valid, s3_valid;
  logic             s1_stall, s2_stall, s3_stall;
  kirw_pkg::words_t s0_words, s1_words, s2_words, s3_words;

  kirw_inject u_inject (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .valid_up   (in_valid),
    .index_up   (stream_index),
    .stall_up   (in_stall),
    .valid      (s0_valid),
    .words      (s0_words),
    .stall_down (s1_stall)
  );

  kirw_mix_stage u_mix_a (
    .clk        (clk),
    .rst        (rst),
    .rnd        (kirw_pkg::ROUND_A),
    .valid_up   (s0_valid),
    .words_up   (s0_words),
    .stall_up   (s1_stall),
    .valid      (s1_valid),
    .words      (s1_words),
    .stall_down (s2_stall)
  );

  kirw_mix_stage u_mix_b (
    .clk        (clk),
    .rst        (rst),
    .rnd        (kirw_pkg::ROUND_B),
    .valid_up   (s1_valid),
    .words_up   (s1_words),
    .stall_up   (s2_stall),
    .valid      (s2_valid),
    .words      (s2_words),
    .stall_down (s3_stall)
  );

  kirw_mix_stage u_mix_c (
    .clk        (clk),
    .rst        (rst),
    .rnd        (kirw_pkg::ROUND_C),
    .valid_up   (s2_valid),
    .words_up   (s2_words),
    .stall_up   (s3_stall),
    .valid      (s3_valid),
    .words      (s3_words),
    .stall_down (out_stall)
  );

  // The final stage register serves as the output register; the result is
  // the XOR of mixed words zero and three.
  assign out_valid   = s3_valid;
  assign random_word = s3_words[0] ^ s3_words[3];

  // The index side can only be held off when every stage is full and the
  // result is being held.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s0_valid && s1_valid && s2_valid && out_valid && out_stall))
    else $error("index stalled while the pipeline has room");

  // A free result side never pushes back on the index side.
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("index stalled although results drain");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s0_valid && !s1_valid && !s2_valid && !out_valid))
    else $error("pipeline holds a transaction after reset");

  // A transaction held at the output leaves the earlier stages unchanged
  // only if they are full; an accepted one passes the injection stage and the
  // three mixing stages to reach the output when nothing stalls.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("transaction lost in the pipeline");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed index random word generator. A short
// table of corner-case indexes runs first, then randomized index streams run
// under a series of key settings. Each result is checked against a local
// model of the mixing round, with bursty input traffic and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  // Four register stages from an accepted index to its word at the port.
  localparam int PIPE_LATENCY    = 4;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int RANDOM_PHASES   = 6;
  localparam int DIRECTED_ROWS   = 12;

  typedef logic [kirw_pkg::CfgIdxBits-1:0] cfg_index_t;

  // Configuration register map. Indexes six and seven decode to nothing, so
  // writes to them must leave the key untouched.
  localparam cfg_index_t KEY_WORD_0    = 3'd0;
  localparam cfg_index_t SPARE_INDEX_6 = 3'd6;
  localparam cfg_index_t SPARE_INDEX_7 = 3'd7;

  // Backpressure styles that the result side cycles through.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // One row of the corner-case table. When known is set, word is the result
  // that follows directly from the index under the all-zero reset key.
  typedef struct {
    logic [kirw_pkg::IndexBits-1:0] index;
    bit                             known;
    kirw_pkg::word_t                word;
  } index_row_t;

  // Clock, reset and the ports of the block.
  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [kirw_pkg::IndexBits-1:0] stream_index = '0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  kirw_pkg::word_t                random_word;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  cfg_index_t                     cfg_index    = '0;
  kirw_pkg::word_t                cfg_data     = '0;

  // Bench state: our copy of the key, words still owed by the block and a
  // few counters for the closing summary.
  kirw_pkg::words_t key_shadow = '0;
  kirw_pkg::word_t  pending_words[$];
  kirw_pkg::word_t  owed_word;
  index_row_t       directed_rows[DIRECTED_ROWS];
  int               error_count     = 0;
  int               indexes_sent    = 0;
  int               words_checked   = 0;
  int               key_settings    = 1;
  int               burst_left      = 0;
  int               segment_left    = 0;
  int               stall_tick      = 0;
  stall_mode_t      stall_mode      = STALL_NONE;

  always #5 clk = ~clk;

  keyed_index_random_word dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stream_index (stream_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_word  (random_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Rotation amounts are never zero here, so the right shift stays in range.
  function automatic kirw_pkg::word_t rotate_left(kirw_pkg::word_t x, int unsigned amount);
    return (x << amount) | (x >> (kirw_pkg::WordBits - amount));
  endfunction

  // Computes the word the block owes for one index under the current key.
  // The index halves are folded into the first four key words, then three
  // quarter-rounds of add, xor and rotate run over all six words. All sums
  // wrap at 32 bits because every operand is a word_t.
  function automatic kirw_pkg::word_t predict_random_word(
      logic [kirw_pkg::IndexBits-1:0] index);
    kirw_pkg::words_t s;
    kirw_pkg::word_t  lo;
    kirw_pkg::word_t  hi;
    s  = key_shadow;
    lo = index[31:0];
    hi = index[63:32];
    s[0] = s[0] + lo;
    s[1] = s[1] ^ lo;
    s[2] = s[2] + hi;
    s[3] = s[3] ^ hi;
    // First quarter: word 1 takes a difference.
    s[0] = rotate_left(s[0], 7);
    s[1] = s[1] - s[0];
    s[2] = rotate_left(s[2] ^ s[1], 9);
    s[3] = s[3] + s[2];
    s[4] = rotate_left(s[4] ^ s[3], 13);
    s[5] = s[5] + s[4];
    s[0] = s[0] ^ s[5];
    // Second quarter: word 3 takes a difference.
    s[0] = rotate_left(s[0], 18);
    s[1] = s[1] + s[0];
    s[2] = rotate_left(s[2] ^ s[1], 7);
    s[3] = s[3] - s[2];
    s[4] = rotate_left(s[4] ^ s[3], 9);
    s[5] = s[5] + s[4];
    s[0] = s[0] ^ s[5];
    // Third quarter: word 5 takes a difference.
    s[0] = rotate_left(s[0], 13);
    s[1] = s[1] + s[0];
    s[2] = rotate_left(s[2] ^ s[1], 18);
    s[3] = s[3] + s[2];
    s[4] = rotate_left(s[4] ^ s[3], 12);
    s[5] = s[5] - s[4];
    s[0] = s[0] ^ s[5];
    return s[0] ^ s[3];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tasks. All of them are entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one index and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid drops for a random gap. valid is
  // only lowered when a real gap follows, so it never toggles within a step.
  task automatic send_index(input logic [kirw_pkg::IndexBits-1:0] index, input bit known,
                            input kirw_pkg::word_t known_word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    stream_index <= index;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(known ? known_word : predict_random_word(index));
    burst_left--;
    indexes_sent++;
  endtask

  // One register write transaction. valid is left high so that back-to-back
  // writes need no second assignment in the same step; load_key lowers it.
  task automatic cfg_write(input cfg_index_t index, input kirw_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index < kirw_pkg::KeyWords) begin
      key_shadow[index] = data;
    end
  endtask

  // Loads a full key. Writes to the two undecoded indexes bracket the key
  // words, so a decode fault would corrupt the key and show up in the data.
  task automatic load_key(input kirw_pkg::words_t key);
    cfg_write(SPARE_INDEX_6, $urandom);
    for (int k = 0; k < kirw_pkg::KeyWords; k++) begin
      cfg_write(KEY_WORD_0 + cfg_index_t'(k), key[k]);
    end
    cfg_write(SPARE_INDEX_7, $urandom);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  // Drops valid and waits until every owed word has come back, then lets
  // the pipeline settle before anything touches the key.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: checks each accepted transaction and drives the stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          $display("%0t ns: unexpected random_word 0x%08h with nothing owed",
                   $time, random_word);
          error_count++;
        end else begin
          owed_word = pending_words.pop_front();
          words_checked++;
          if (random_word !== owed_word) begin
            $display("%0t ns: random_word mismatch, expected 0x%08h, actual 0x%08h",
                     $time, owed_word, random_word);
            error_count++;
          end
        end
      end
      // The stall style changes after a segment of random length, so
      // stalls land on every pipeline stage and quiet stretches occur too.
      if (segment_left == 0) begin
        stall_mode   = stall_mode_t'($urandom_range(0, 3));
        segment_left = $urandom_range(20, 200);
      end else begin
        segment_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= (stall_tick % 7) < 3;
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kirw_pkg::words_t               key;
    logic [kirw_pkg::IndexBits-1:0] index;
    logic [kirw_pkg::IndexBits-1:0] run_base;

    // Corner indexes. Under the all-zero reset key a zero index leaves all
    // six words at zero through every step, so its word must be zero.
    directed_rows = '{
      '{64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{64'h0000_0000_FFFF_FFFF, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_0000_0000, 1'b0, 32'h0},
      '{64'h0000_0000_0000_0001, 1'b0, 32'h0},
      '{64'h8000_0000_0000_0000, 1'b0, 32'h0},
      '{64'h0000_0001_0000_0000, 1'b0, 32'h0},
      '{64'h0000_0000_8000_0000, 1'b0, 32'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 32'h0},
      '{64'h0123_4567_89AB_CDEF, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 32'h0}
    };

    // Synchronous reset, held from the start and then released.
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass one of the table runs on the reset key, where the known word of
    // the zero row applies. Pass two runs on an all-ones key, loaded along
    // with writes to the undecoded indexes, and relies on the model alone.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_index(directed_rows[i].index, directed_rows[i].known, directed_rows[i].word);
    end
    drain();
    load_key('1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_index(directed_rows[i].index, 1'b0, '0);
    end
    drain();

    // Random phases. The first key is fully random; later ones mix in the
    // extreme word values so carries and rotations hit their edges.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int k = 0; k < kirw_pkg::KeyWords; k++) begin
        case (phase == 0 ? 5 : $urandom_range(0, 5))
          0:       key[k] = '0;
          1:       key[k] = '1;
          2:       key[k] = 32'h8000_0000;
          3:       key[k] = 32'h0000_0001;
          default: key[k] = $urandom;
        endcase
      end
      load_key(key);
      run_base = {$urandom, $urandom};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Counter streams are the normal use, so a good share of the indexes
        // walk upward from a random base, including across the 32-bit carry.
        case ($urandom_range(0, 9))
          0: index = {32'h0, $urandom};
          1: index = {$urandom, 32'hFFFF_FFFF};
          2: begin
            if ($urandom_range(0, 15) == 0) begin
              run_base = {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))};
            end
            index    = run_base;
            run_base = run_base + 1;
          end
          3: begin
            index    = run_base;
            run_base = run_base + 1;
          end
          default: index = {$urandom, $urandom};
        endcase
        send_index(index, 1'b0, '0);
      end
      drain();
    end

    $display("Ran %0d indexes under %0d key settings, %0d corner cases included.",
             indexes_sent, key_settings, 2 * DIRECTED_ROWS);
    $display("Checked %0d random words with bursty input and varied output stalls.",
             words_checked);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("keyed_index_random_word regression: pass");
    end else begin
      $display("keyed_index_random_word regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d words still owed.", pending_words.size());
    $display("keyed_index_random_word regression: fail");
    $finish;
  end

endmodule
